// ===== rtl/cpcl_pkg.sv =====
// Package for the chassis power current limiter: widths, reset values,
// register indexes, limit modes and pipeline latencies.
// No dependencies.
`default_nettype none

package cpcl_pkg;

  localparam int CUR_W   = 16;  // signed motor current
  localparam int PWR_W   = 14;  // power, energy and thresholds
  localparam int BUD_W   = 16;  // current budgets
  localparam int LIM_W   = 17;  // total current limit
  localparam int TOT_W   = 18;  // sum of four magnitudes
  localparam int N_LANES = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Limit divider: budget (16 b) times a 14 b operand over a 14 b divisor.
  localparam int LIM_NUM_W = BUD_W + PWR_W;
  localparam int LIM_Q_W   = LIM_NUM_W;
  localparam int LIMIT_LAT = LIM_Q_W + 1;

  // Lane divider: magnitude times limit over total, quotient below 2^CUR_W.
  localparam int PROD_W   = CUR_W + LIM_W;
  localparam int LANE_LAT = CUR_W + 1;

  localparam logic [LIM_W-1:0] LIMIT_CAP = 17'd131070;

  localparam int NO_LIMIT_TOTAL_DEF   = 64000;
  localparam int MIN_BUFFER_FLOOR_DEF = 320;

  localparam logic [PWR_W-1:0] RST_PLIM_LO = 14'd2240;
  localparam logic [PWR_W-1:0] RST_WPOW_LO = 14'd768;
  localparam logic [PWR_W-1:0] RST_WBUF_LO = 14'd512;
  localparam logic [PWR_W-1:0] RST_PLIM_HI = 14'd3200;
  localparam logic [PWR_W-1:0] RST_WPOW_HI = 14'd1280;
  localparam logic [PWR_W-1:0] RST_WBUF_HI = 14'd640;
  localparam logic [BUD_W-1:0] RST_BUF_BUDGET = 16'd10000;
  localparam logic [BUD_W-1:0] RST_PWR_BUDGET = 16'd15000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLIM_LO    = 3'd0,
    CFG_WPOW_LO    = 3'd1,
    CFG_WBUF_LO    = 3'd2,
    CFG_PLIM_HI    = 3'd3,
    CFG_WPOW_HI    = 3'd4,
    CFG_WBUF_HI    = 3'd5,
    CFG_BUF_BUDGET = 3'd6,
    CFG_PWR_BUDGET = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,  // referee lost or unlimited robot
    MODE_BUFFER = 2'd1,  // buffer below warning
    MODE_RAMP   = 2'd2,  // above warning power
    MODE_FULL   = 2'd3   // at or below warning power
  } lim_mode_e;

endpackage

`default_nettype wire

// ===== rtl/chassis_power_current_limiter.sv =====
// Top level of the chassis power current limiter: config registers, limit
// selection, limit divider, four current lanes and output register.
// Depends on cpcl_pkg, cpcl_div and cpcl_lane.
//
//  channel    dir  width          contents
//  s_axis     in   tdata 96       meas_power, buffer_energy, motor_current_0..3
//                  tuser 3        referee_error, unlimited_robot, level_two
//  m_axis     out  tdata 88       limited_current_0..3, total_limit
//                  tuser 1        was_scaled
//  cfg        in   idx 3, data 16 threshold and budget registers, write only
//
// One word enters per cycle while the output is not stalled; each word passes through
// one select stage, 31 limit-divider stages, one sum stage, 17 lane stages and the
// output register. The two dividers settle one quotient bit per stage.
// Reset clears valid bits and restores register defaults; data holds no reset.
// A stalled output freezes the whole pipeline; s_axis_tready follows it.
`default_nettype none

module chassis_power_current_limiter
  import cpcl_pkg::*;
#(
  parameter int NO_LIMIT_TOTAL   = NO_LIMIT_TOTAL_DEF,
  parameter int MIN_BUFFER_FLOOR = MIN_BUFFER_FLOOR_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // tdata: meas_power[13:0], buffer_energy[27:14], motor_current_0[43:28],
  //        motor_current_1[59:44], motor_current_2[75:60], motor_current_3[91:76]
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [95:0]          s_axis_tdata,
  // tuser: referee_error[0], unlimited_robot[1], level_two[2]
  input  wire logic [2:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: limited_current_0[15:0], limited_current_1[31:16],
  //        limited_current_2[47:32], limited_current_3[63:48], total_limit[80:64]
  output logic [87:0]               m_axis_tdata,
  // tuser: was_scaled[0]
  output logic [0:0]                m_axis_tuser,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int VLAT = 1 + LIMIT_LAT + 1 + LANE_LAT;
  localparam int SIDE_W = 2 + 2 * BUD_W + N_LANES * CUR_W;
  localparam logic [PWR_W-1:0] FLOOR = PWR_W'(MIN_BUFFER_FLOOR);
  localparam logic [LIM_W-1:0] NO_LIM = LIM_W'(NO_LIMIT_TOTAL);

  // ---------------------------------------------------------------- config
  logic [PWR_W-1:0] plim_lo_q, wpow_lo_q, wbuf_lo_q;
  logic [PWR_W-1:0] plim_hi_q, wpow_hi_q, wbuf_hi_q;
  logic [BUD_W-1:0] buf_budget_q, pwr_budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plim_lo_q    <= RST_PLIM_LO;
      wpow_lo_q    <= RST_WPOW_LO;
      wbuf_lo_q    <= RST_WBUF_LO;
      plim_hi_q    <= RST_PLIM_HI;
      wpow_hi_q    <= RST_WPOW_HI;
      wbuf_hi_q    <= RST_WBUF_HI;
      buf_budget_q <= RST_BUF_BUDGET;
      pwr_budget_q <= RST_PWR_BUDGET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PLIM_LO:    plim_lo_q    <= cfg_data_i[PWR_W-1:0];
        CFG_WPOW_LO:    wpow_lo_q    <= cfg_data_i[PWR_W-1:0];
        CFG_WBUF_LO:    wbuf_lo_q    <= cfg_data_i[PWR_W-1:0];
        CFG_PLIM_HI:    plim_hi_q    <= cfg_data_i[PWR_W-1:0];
        CFG_WPOW_HI:    wpow_hi_q    <= cfg_data_i[PWR_W-1:0];
        CFG_WBUF_HI:    wbuf_hi_q    <= cfg_data_i[PWR_W-1:0];
        CFG_BUF_BUDGET: buf_budget_q <= cfg_data_i;
        CFG_PWR_BUDGET: pwr_budget_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // One enable for every stage: advance unless a finished word waits.
  logic             en;
  logic [VLAT-1:0]  valid_q;
  logic             out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[VLAT-2:0], s_axis_tvalid};
      out_valid_q <= valid_q[VLAT-1];
    end
  end

  // ---------------------------------------------------------------- select
  // Pick the threshold set and reduce every branch to one division a*b/den.
  logic [PWR_W-1:0] power, buffer, plim, wpow, wbuf, num_buf;
  lim_mode_e        mode_d;
  logic [BUD_W-1:0] opa_d;
  logic [PWR_W-1:0] opb_d, den_d;

  assign power  = s_axis_tdata[13:0];
  assign buffer = s_axis_tdata[27:14];
  assign plim   = s_axis_tuser[2] ? plim_hi_q : plim_lo_q;
  assign wpow   = s_axis_tuser[2] ? wpow_hi_q : wpow_lo_q;
  assign wbuf   = s_axis_tuser[2] ? wbuf_hi_q : wbuf_lo_q;
  assign num_buf = (buffer > FLOOR) ? buffer : FLOOR;

  always_comb begin
    mode_d = MODE_FULL;
    opa_d  = '0;
    opb_d  = '0;
    den_d  = PWR_W'(1);
    if (s_axis_tuser[0] || s_axis_tuser[1]) begin
      mode_d = MODE_FIXED;
    end else if (buffer < wbuf) begin
      mode_d = MODE_BUFFER;
      opa_d  = buf_budget_q;
      opb_d  = num_buf;
      den_d  = wbuf;
    end else if (power > wpow) begin
      mode_d = MODE_RAMP;
      // Past the power limit the extra term drops to zero.
      if (power < plim) begin
        opa_d = pwr_budget_q;
        opb_d = plim - power;
        den_d = plim - wpow;
      end
    end
  end

  lim_mode_e        mode_q;
  logic [BUD_W-1:0] opa_q, bud_buf_q, bud_pwr_q;
  logic [PWR_W-1:0] opb_q, den_q;
  logic [N_LANES*CUR_W-1:0] cur1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q    <= mode_d;
      opa_q     <= opa_d;
      opb_q     <= opb_d;
      den_q     <= den_d;
      bud_buf_q <= buf_budget_q;
      bud_pwr_q <= pwr_budget_q;
      cur1_q    <= s_axis_tdata[91:28];
    end
  end

  // ---------------------------------------------------------------- limit divider
  logic [LIM_NUM_W-1:0] lim_num;
  logic [LIM_Q_W-1:0]   lim_quo;
  logic [SIDE_W-1:0]    lim_side;

  assign lim_num = LIM_NUM_W'(opa_q) * LIM_NUM_W'(opb_q);

  cpcl_div #(
    .NUM_W  (LIM_NUM_W),
    .DEN_W  (PWR_W),
    .Q_W    (LIM_Q_W),
    .SIDE_W (SIDE_W)
  ) u_limit_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (lim_num),
    .den_i  (den_q),
    .side_i ({2'(mode_q), bud_buf_q, bud_pwr_q, cur1_q}),
    .quo_o  (lim_quo),
    .side_o (lim_side)
  );

  // ---------------------------------------------------------------- limit and sum
  lim_mode_e        mode_l;
  logic [BUD_W-1:0] bud_buf_l, bud_pwr_l;
  logic [LIM_W-1:0] limit_d;
  logic [CUR_W-1:0] cur_l [N_LANES];
  logic [CUR_W-1:0] mag_d [N_LANES];
  logic [TOT_W-1:0] total_d;

  assign mode_l    = lim_mode_e'(lim_side[SIDE_W-1 -: 2]);
  assign bud_buf_l = lim_side[N_LANES*CUR_W + BUD_W +: BUD_W];
  assign bud_pwr_l = lim_side[N_LANES*CUR_W +: BUD_W];

  always_comb begin
    case (mode_l)
      MODE_FIXED:  limit_d = NO_LIM;
      MODE_BUFFER: limit_d = (lim_quo > LIM_Q_W'(LIMIT_CAP)) ? LIMIT_CAP
                                                             : lim_quo[LIM_W-1:0];
      MODE_RAMP:   limit_d = LIM_W'(bud_buf_l) + LIM_W'(lim_quo[BUD_W-1:0]);
      MODE_FULL:   limit_d = LIM_W'(bud_buf_l) + LIM_W'(bud_pwr_l);
      default:     limit_d = NO_LIM;
    endcase
  end

  always_comb begin
    total_d = '0;
    for (int i = 0; i < N_LANES; i++) begin
      cur_l[i] = lim_side[i*CUR_W +: CUR_W];
      mag_d[i] = cur_l[i][CUR_W-1] ? CUR_W'(0) - cur_l[i] : cur_l[i];
      total_d  = total_d + TOT_W'(mag_d[i]);
    end
  end

  logic [LIM_W-1:0] limit_q;
  logic [TOT_W-1:0] total_q;
  logic [CUR_W-1:0] mag_q [N_LANES];
  logic [CUR_W-1:0] cur2_q [N_LANES];
  logic             scale;

  always_ff @(posedge clk_i) begin
    if (en) begin
      limit_q <= limit_d;
      total_q <= total_d;
      for (int i = 0; i < N_LANES; i++) begin
        mag_q[i]  <= mag_d[i];
        cur2_q[i] <= cur_l[i];
      end
    end
  end

  assign scale = total_q > TOT_W'(limit_q);

  // ---------------------------------------------------------------- lanes
  logic signed [CUR_W-1:0] lane_cur [N_LANES];

  for (genvar i = 0; i < N_LANES; i++) begin : g_lane
    cpcl_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .cur_i   (cur2_q[i]),
      .mag_i   (mag_q[i]),
      .limit_i (limit_q),
      .total_i (total_q),
      .scale_i (scale),
      .cur_o   (lane_cur[i])
    );
  end

  // Hold limit and scale flag beside the lanes until their results come out.
  logic [LIM_W-1:0] limit_dl_q [LANE_LAT];
  logic             scale_dl_q [LANE_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      limit_dl_q[0] <= limit_q;
      scale_dl_q[0] <= scale;
      for (int k = 1; k < LANE_LAT; k++) begin
        limit_dl_q[k] <= limit_dl_q[k-1];
        scale_dl_q[k] <= scale_dl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- merge / output
  logic [N_LANES*CUR_W-1:0] out_cur_q;
  logic [LIM_W-1:0]         out_limit_q;
  logic                     out_scaled_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < N_LANES; i++) begin
        out_cur_q[i*CUR_W +: CUR_W] <= lane_cur[i];
      end
      out_limit_q  <= limit_dl_q[LANE_LAT-1];
      out_scaled_q <= scale_dl_q[LANE_LAT-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_limit_q, out_cur_q};
  assign m_axis_tuser  = out_scaled_q;

  // ---------------------------------------------------------------- checks
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(valid_q))
    else $error("pipeline moved while output stalled");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_q[VLAT-1]))
    else $error("output word without a pipeline word behind it");

  a_limit_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_limit_q <= LIMIT_CAP))
    else $error("total limit above cap");

endmodule

`default_nettype wire

// ===== rtl/cpcl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side
// payload carried alongside. Uses no package.
`default_nettype none

module cpcl_div #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 18,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic      [Q_W-1:0]    quo_o,
  output logic      [SIDE_W-1:0] side_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]     rem_q  [0:Q_W];
  logic [DEN_W-1:0]  den_q  [0:Q_W];
  logic [Q_W-1:0]    quo_q  [0:Q_W];
  logic [SIDE_W-1:0] side_q [0:Q_W];

  logic [CW-1:0]  rem_d [1:Q_W];
  logic [Q_W-1:0] quo_d [1:Q_W];

  // Stage k settles quotient bit Q_W-k.
  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    localparam int B = Q_W - k;
    logic [CW-1:0] shifted;
    assign shifted = CW'(den_q[k-1]) << B;
    always_comb begin
      if (rem_q[k-1] >= shifted) begin
        rem_d[k] = rem_q[k-1] - shifted;
        quo_d[k] = quo_q[k-1] | (Q_W'(1) << B);
      end else begin
        rem_d[k] = rem_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= CW'(num_i);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
      for (int k = 1; k <= Q_W; k++) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= quo_d[k];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign quo_o  = quo_q[Q_W];
  assign side_o = side_q[Q_W];

endmodule

`default_nettype wire

// ===== rtl/cpcl_lane.sv =====
// One motor lane: when scaling, magnitude times limit, divide by total, restore sign; else pass the current.
// Depends on cpcl_pkg and cpcl_div.
`default_nettype none

module cpcl_lane
  import cpcl_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [CUR_W-1:0] cur_i,
  input  wire logic        [CUR_W-1:0] mag_i,
  input  wire logic        [LIM_W-1:0] limit_i,
  input  wire logic        [TOT_W-1:0] total_i,
  input  wire logic                    scale_i,
  output logic signed      [CUR_W-1:0] cur_o
);

  logic [PROD_W-1:0] prod;
  logic [CUR_W-1:0]  quo;
  logic [CUR_W:0]    side_out;
  logic [CUR_W-1:0]  cur_dly;

  assign prod = PROD_W'(mag_i) * PROD_W'(limit_i);

  cpcl_div #(
    .NUM_W  (PROD_W),
    .DEN_W  (TOT_W),
    .Q_W    (CUR_W),
    .SIDE_W (CUR_W + 1)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (prod),
    .den_i  (total_i),
    .side_i ({scale_i, cur_i}),
    .quo_o  (quo),
    .side_o (side_out)
  );

  assign cur_dly = side_out[CUR_W-1:0];

  // Truncate toward zero: scale the magnitude, then put the sign back.
  always_comb begin
    if (!side_out[CUR_W]) begin
      cur_o = cur_dly;
    end else if (cur_dly[CUR_W-1]) begin
      cur_o = CUR_W'(0) - quo;
    end else begin
      cur_o = quo;
    end
  end

endmodule

`default_nettype wire
